FILE: rtl/core/bmprd_pkg.sv
package bmprd_pkg;

    localparam int MAX_WIDTH_DEF       = 4096;
    localparam int MAX_HEIGHT_DEF      = 4096;
    localparam int PALETTE_ENTRIES_DEF = 256;

    localparam int COORD_W    = 12;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;

    // pixel_format codes
    localparam logic [2:0] FMT_1BPP  = 3'd0;
    localparam logic [2:0] FMT_4BPP  = 3'd1;
    localparam logic [2:0] FMT_8BPP  = 3'd2;
    localparam logic [2:0] FMT_16BPP = 3'd3;
    localparam logic [2:0] FMT_24BPP = 3'd4;
    localparam logic [2:0] FMT_32BPP = 3'd5;

    // item kinds on tuser
    localparam logic KIND_PALETTE = 1'b0;
    localparam logic KIND_DATA    = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_BIT_MASKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RED_MASK      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_MASK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_MASK     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_UP     = 3'd7;

    localparam logic [31:0] RED_MASK_RST   = 32'h00FF_0000;
    localparam logic [31:0] GREEN_MASK_RST = 32'h0000_FF00;
    localparam logic [31:0] BLUE_MASK_RST  = 32'h0000_00FF;
    localparam logic [4:0]  RED_SHIFT_RST   = 5'd16;
    localparam logic [4:0]  GREEN_SHIFT_RST = 5'd8;
    localparam logic [4:0]  BLUE_SHIFT_RST  = 5'd0;

    localparam logic [15:0] MASK555_RED   = 16'h7C00;
    localparam logic [15:0] MASK555_GREEN = 16'h03E0;
    localparam logic [15:0] MASK555_BLUE  = 16'h001F;

    typedef struct packed {
        logic [2:0]  pixel_format;
        logic        use_bit_masks;
        logic [31:0] red_mask;
        logic [31:0] green_mask;
        logic [31:0] blue_mask;
        logic [4:0]  red_shift;
        logic [4:0]  green_shift;
        logic [4:0]  blue_shift;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic        bottom_up;
    } cfg_t;

    typedef struct packed {
        logic              is_pal;
        logic [7:0]        pal_idx;
        logic [23:0]       rgb;
        logic [COORD_W-1:0] dest_row;
        logic [COORD_W-1:0] column;
        logic              last;
    } pix_req_t;

    typedef struct packed {
        logic        en;
        logic [7:0]  index;
        logic [23:0] rgb;
    } pal_wr_t;

endpackage

FILE: rtl/core/bmp_row_pixel_decoder_core.sv
// Bitmap row pixel decoder: takes one byte of row data (or one palette write) per item and
// returns 8-bit red, green, blue pixels tagged with destination row and column. A data byte
// yields zero to eight pixels (up to eight at 1 bit per pixel, up to two at 4, one at 8, one
// per completed 16/24/32-bit pixel, none for padding), and the output port drains one pixel
// per cycle while m_tready is high, so a byte of n pixels holds off the next input while
// the run register empties. An accepted byte reaches its first pixel through the run
// register, then the palette read and output register. Palette entries are undefined
// until written. Configure only while no item is in flight.
module bmp_row_pixel_decoder_core #(
    parameter int MAX_WIDTH       = bmprd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT      = bmprd_pkg::MAX_HEIGHT_DEF,
    parameter int PALETTE_ENTRIES = bmprd_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // data_byte, palette_index, palette_red, palette_green, palette_blue
    input  logic [bmprd_pkg::IN_DATA_W-1:0]   s_tdata,
    // kind
    input  logic                              s_tuser,
    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // red, green, blue, dest_row, column
    output logic [bmprd_pkg::OUT_DATA_W-1:0]  m_tdata,
    // last_of_run
    output logic                              m_tlast,
    // register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bmprd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                       cfg_data
);

    bmprd_pkg::cfg_t     cfg;
    bmprd_pkg::pal_wr_t  pal_wr;
    bmprd_pkg::pix_req_t req;
    logic                req_valid, req_ready;

    bmprd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bmprd_unpack #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_unpack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .pal_wr    (pal_wr),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req)
    );

    bmprd_out #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pal_wr    (pal_wr),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: rtl/core/bmprd_cfg.sv
module bmprd_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bmprd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                      cfg_data,
    output bmprd_pkg::cfg_t                  cfg
);

    bmprd_pkg::cfg_t cfg_reg, cfg_next;
    logic            wr_en;

    // count of trailing zeros, mask of zero gives a don't-care shift
    function automatic logic [4:0] trailing_zeros(input logic [31:0] m);
        logic [4:0] s;
        s = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (m[i]) begin
                s = 5'(i);
            end
        end
        return s;
    endfunction

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (cfg_index)
                bmprd_pkg::REG_PIXEL_FORMAT:  cfg_next.pixel_format  = cfg_data[2:0];
                bmprd_pkg::REG_USE_BIT_MASKS: cfg_next.use_bit_masks = cfg_data[0];
                bmprd_pkg::REG_RED_MASK: begin
                    cfg_next.red_mask  = cfg_data;
                    cfg_next.red_shift = trailing_zeros(cfg_data);
                end
                bmprd_pkg::REG_GREEN_MASK: begin
                    cfg_next.green_mask  = cfg_data;
                    cfg_next.green_shift = trailing_zeros(cfg_data);
                end
                bmprd_pkg::REG_BLUE_MASK: begin
                    cfg_next.blue_mask  = cfg_data;
                    cfg_next.blue_shift = trailing_zeros(cfg_data);
                end
                bmprd_pkg::REG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_data[12:0];
                bmprd_pkg::REG_IMAGE_HEIGHT: cfg_next.image_height = cfg_data[12:0];
                bmprd_pkg::REG_BOTTOM_UP:    cfg_next.bottom_up    = cfg_data[0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pixel_format  <= bmprd_pkg::FMT_24BPP;
            cfg_reg.use_bit_masks <= 1'b0;
            cfg_reg.red_mask      <= bmprd_pkg::RED_MASK_RST;
            cfg_reg.green_mask    <= bmprd_pkg::GREEN_MASK_RST;
            cfg_reg.blue_mask     <= bmprd_pkg::BLUE_MASK_RST;
            cfg_reg.red_shift     <= bmprd_pkg::RED_SHIFT_RST;
            cfg_reg.green_shift   <= bmprd_pkg::GREEN_SHIFT_RST;
            cfg_reg.blue_shift    <= bmprd_pkg::BLUE_SHIFT_RST;
            cfg_reg.image_width   <= 13'd1;
            cfg_reg.image_height  <= 13'd1;
            cfg_reg.bottom_up     <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/core/bmprd_unpack.sv
module bmprd_unpack #(
    parameter int MAX_WIDTH  = bmprd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bmprd_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  bmprd_pkg::cfg_t                  cfg,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bmprd_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                             s_tuser,
    output bmprd_pkg::pal_wr_t               pal_wr,
    output logic                             req_valid,
    input  logic                             req_ready,
    output bmprd_pkg::pix_req_t              req
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int PW = $clog2(MAX_WIDTH) + 3;

    // derived geometry
    logic [WW-1:0] width;
    logic [HW-1:0] height;
    logic [PW:0]   wide_w, row_bytes, pitch;

    // per-row state
    logic [23:0]   asm_reg, asm_next;
    logic [1:0]    bip_reg, bip_next;
    logic [WW-1:0] col_reg, col_next;
    logic [PW-1:0] rbc_reg, rbc_next;
    logic [HW-1:0] row_reg, row_next;

    // run register: one accepted byte draining its pixels
    logic          run_valid_reg, run_valid_next;
    logic [7:0]    run_byte_reg, run_byte_next;
    logic [2:0]    run_fmt_reg, run_fmt_next;
    logic [2:0]    run_k_reg, run_k_next;
    logic [3:0]    run_left_reg, run_left_next;
    logic [WW-1:0] run_col_reg, run_col_next;
    logic [bmprd_pkg::COORD_W-1:0] run_dest_reg, run_dest_next;
    logic [23:0]   run_rgb_reg, run_rgb_next;

    logic          s_fire, data_go, in_row, is_direct, complete, load, req_fire, row_end;
    logic [7:0]    d;
    logic [HW-1:0] rc_eff, dest;
    logic [WW-1:0] rem;
    logic [3:0]    n;
    logic [2:0]    need;
    logic [31:0]   word_raw, word;
    logic [7:0]    r, g, b;
    logic [PW:0]   rbc_inc;

    assign d = s_tdata[7:0];

    always_comb begin
        if (cfg.image_width == 13'd0) begin
            width = WW'(1);
        end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
            width = WW'(MAX_WIDTH);
        end else begin
            width = WW'(cfg.image_width);
        end
        if (cfg.image_height == 13'd0) begin
            height = HW'(1);
        end else if (32'(cfg.image_height) > 32'(MAX_HEIGHT)) begin
            height = HW'(MAX_HEIGHT);
        end else begin
            height = HW'(cfg.image_height);
        end
    end

    assign wide_w = (PW+1)'(width);

    always_comb begin
        case (cfg.pixel_format)
            bmprd_pkg::FMT_1BPP:  row_bytes = (wide_w + (PW+1)'(7)) >> 3;
            bmprd_pkg::FMT_4BPP:  row_bytes = (wide_w + (PW+1)'(1)) >> 1;
            bmprd_pkg::FMT_8BPP:  row_bytes = wide_w;
            bmprd_pkg::FMT_16BPP: row_bytes = wide_w << 1;
            bmprd_pkg::FMT_24BPP: row_bytes = wide_w + (wide_w << 1);
            bmprd_pkg::FMT_32BPP: row_bytes = wide_w << 2;
            default:              row_bytes = wide_w;
        endcase
    end

    // rows are padded to whole 32-bit words
    assign pitch = (row_bytes + (PW+1)'(3)) & ~((PW+1)'(3));

    assign req_fire = req_valid && req_ready;
    assign s_tready = !run_valid_reg || (run_left_reg == 4'd1 && req_ready);
    assign s_fire   = s_tvalid && s_tready;
    assign data_go  = s_fire && (s_tuser == bmprd_pkg::KIND_DATA)
                      && (cfg.pixel_format <= bmprd_pkg::FMT_32BPP);

    assign rc_eff = (row_reg >= height) ? HW'(0) : row_reg;
    assign dest   = cfg.bottom_up ? (height - HW'(1) - rc_eff) : rc_eff;
    assign in_row = col_reg < width;
    assign rem    = width - col_reg;

    assign is_direct = cfg.pixel_format >= bmprd_pkg::FMT_16BPP;

    always_comb begin
        case (cfg.pixel_format)
            bmprd_pkg::FMT_16BPP: need = 3'd2;
            bmprd_pkg::FMT_24BPP: need = 3'd3;
            default:              need = 3'd4;
        endcase
    end

    assign complete = ({1'b0, bip_reg} + 3'd1) >= need;
    assign word_raw = {8'd0, asm_reg} | (32'(d) << {bip_reg, 3'b000});
    assign word     = (cfg.pixel_format == bmprd_pkg::FMT_16BPP)
                      ? (word_raw & 32'h0000_FFFF) : word_raw;

    always_comb begin
        if (cfg.pixel_format != bmprd_pkg::FMT_24BPP && cfg.use_bit_masks) begin
            r = 8'((word & cfg.red_mask)   >> cfg.red_shift);
            g = 8'((word & cfg.green_mask) >> cfg.green_shift);
            b = 8'((word & cfg.blue_mask)  >> cfg.blue_shift);
        end else if (cfg.pixel_format == bmprd_pkg::FMT_16BPP) begin
            r = 8'((word[15:0] & bmprd_pkg::MASK555_RED)   >> 10);
            g = 8'((word[15:0] & bmprd_pkg::MASK555_GREEN) >> 5);
            b = 8'(word[15:0] & bmprd_pkg::MASK555_BLUE);
        end else begin
            r = word[23:16];
            g = word[15:8];
            b = word[7:0];
        end
    end

    // pixels this byte yields
    always_comb begin
        case (cfg.pixel_format)
            bmprd_pkg::FMT_1BPP: n = (rem >= WW'(8)) ? 4'd8 : 4'(rem);
            bmprd_pkg::FMT_4BPP: n = (rem >= WW'(2)) ? 4'd2 : 4'd1;
            bmprd_pkg::FMT_8BPP: n = 4'd1;
            default:             n = complete ? 4'd1 : 4'd0;
        endcase
    end

    assign load    = data_go && in_row && (n != 4'd0);
    assign rbc_inc = (PW+1)'(rbc_reg) + (PW+1)'(1);
    assign row_end = rbc_inc >= pitch;

    always_comb begin
        asm_next = asm_reg;
        bip_next = bip_reg;
        col_next = col_reg;
        rbc_next = rbc_reg;
        row_next = row_reg;
        if (data_go) begin
            row_next = rc_eff;
            if (in_row) begin
                col_next = col_reg + WW'(n);
                if (is_direct) begin
                    if (complete) begin
                        asm_next = 24'd0;
                        bip_next = 2'd0;
                    end else begin
                        asm_next = word_raw[23:0];
                        bip_next = bip_reg + 2'd1;
                    end
                end
            end
            if (row_end) begin
                rbc_next = '0;
                col_next = '0;
                bip_next = 2'd0;
                asm_next = 24'd0;
                row_next = ((rc_eff + HW'(1)) >= height) ? HW'(0) : rc_eff + HW'(1);
            end else begin
                rbc_next = PW'(rbc_inc);
            end
        end
    end

    always_comb begin
        run_valid_next = run_valid_reg;
        run_byte_next  = run_byte_reg;
        run_fmt_next   = run_fmt_reg;
        run_k_next     = run_k_reg;
        run_left_next  = run_left_reg;
        run_col_next   = run_col_reg;
        run_dest_next  = run_dest_reg;
        run_rgb_next   = run_rgb_reg;
        if (req_fire) begin
            run_k_next    = run_k_reg + 3'd1;
            run_left_next = run_left_reg - 4'd1;
            run_col_next  = run_col_reg + WW'(1);
            if (run_left_reg == 4'd1) begin
                run_valid_next = 1'b0;
            end
        end
        if (load) begin
            run_valid_next = 1'b1;
            run_byte_next  = d;
            run_fmt_next   = cfg.pixel_format;
            run_k_next     = 3'd0;
            run_left_next  = n;
            run_col_next   = col_reg;
            run_dest_next  = bmprd_pkg::COORD_W'(dest);
            run_rgb_next   = {r, g, b};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            asm_reg       <= 24'd0;
            bip_reg       <= 2'd0;
            col_reg       <= '0;
            rbc_reg       <= '0;
            row_reg       <= '0;
            run_valid_reg <= 1'b0;
            run_left_reg  <= 4'd0;
            run_k_reg     <= 3'd0;
        end else begin
            asm_reg       <= asm_next;
            bip_reg       <= bip_next;
            col_reg       <= col_next;
            rbc_reg       <= rbc_next;
            row_reg       <= row_next;
            run_valid_reg <= run_valid_next;
            run_left_reg  <= run_left_next;
            run_k_reg     <= run_k_next;
        end
    end

    always_ff @(posedge aclk) begin
        run_byte_reg <= run_byte_next;
        run_fmt_reg  <= run_fmt_next;
        run_col_reg  <= run_col_next;
        run_dest_reg <= run_dest_next;
        run_rgb_reg  <= run_rgb_next;
    end

    assign pal_wr.en    = s_fire && (s_tuser == bmprd_pkg::KIND_PALETTE);
    assign pal_wr.index = s_tdata[15:8];
    assign pal_wr.rgb   = {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};

    assign req_valid = run_valid_reg;

    always_comb begin
        req.is_pal   = run_fmt_reg <= bmprd_pkg::FMT_8BPP;
        req.rgb      = run_rgb_reg;
        req.dest_row = run_dest_reg;
        req.column   = bmprd_pkg::COORD_W'(run_col_reg);
        req.last     = run_left_reg == 4'd1;
        case (run_fmt_reg)
            bmprd_pkg::FMT_1BPP: req.pal_idx = {7'd0, run_byte_reg[3'(3'd7 - run_k_reg)]};
            bmprd_pkg::FMT_4BPP: req.pal_idx = (run_k_reg == 3'd0)
                                               ? {4'd0, run_byte_reg[7:4]}
                                               : {4'd0, run_byte_reg[3:0]};
            default:             req.pal_idx = run_byte_reg;
        endcase
    end

    a_accept_only_on_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && run_valid_reg) |-> (req_fire && run_left_reg == 4'd1))
        else $error("item taken while run still busy");

    a_run_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (req_fire && run_left_reg == 4'd1 && !load) |=> !run_valid_reg)
        else $error("run not released after its last pixel");

    a_column_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && !row_end) |=> (col_reg <= width))
        else $error("column count ran past image width");

    a_direct_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (run_valid_reg && run_fmt_reg >= bmprd_pkg::FMT_16BPP) |-> run_left_reg == 4'd1)
        else $error("direct colour byte with more than one pixel");

endmodule

FILE: rtl/core/bmprd_out.sv
module bmprd_out #(
    parameter int PALETTE_ENTRIES = bmprd_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  bmprd_pkg::pal_wr_t                pal_wr,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  bmprd_pkg::pix_req_t               req,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bmprd_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                              m_tlast
);

    localparam int AW = $clog2(PALETTE_ENTRIES);

    logic [23:0] palette_mem [0:PALETTE_ENTRIES-1];
    logic [23:0] rd_reg;

    logic        out_valid_reg, out_valid_next;
    logic        is_pal_reg, in_range_reg, last_reg;
    logic [23:0] rgb_reg;
    logic [bmprd_pkg::COORD_W-1:0] dest_reg, col_reg;
    logic        adv, take, wr_ok, rd_ok;
    logic [23:0] rgb_out;

    assign adv       = !out_valid_reg || m_tready;
    assign req_ready = adv;
    assign take      = adv && req_valid;
    assign wr_ok     = {1'b0, pal_wr.index} < 9'(PALETTE_ENTRIES);
    assign rd_ok     = {1'b0, req.pal_idx} < 9'(PALETTE_ENTRIES);

    // read before write at the same entry keeps item order
    always_ff @(posedge aclk) begin
        if (pal_wr.en && wr_ok) begin
            palette_mem[pal_wr.index[AW-1:0]] <= pal_wr.rgb;
        end
        if (take) begin
            rd_reg <= palette_mem[req.pal_idx[AW-1:0]];
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (adv) begin
            out_valid_next = req_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            is_pal_reg   <= req.is_pal;
            in_range_reg <= rd_ok;
            rgb_reg      <= req.rgb;
            dest_reg     <= req.dest_row;
            col_reg      <= req.column;
            last_reg     <= req.last;
        end
    end

    always_comb begin
        if (!is_pal_reg) begin
            rgb_out = rgb_reg;
        end else if (in_range_reg) begin
            rgb_out = rd_reg;
        end else begin
            rgb_out = 24'd0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {col_reg, dest_reg, rgb_out[7:0], rgb_out[15:8], rgb_out[23:16]};
    assign m_tlast  = last_reg;

endmodule
